// ===== rtl/core/assert_macros.svh =====
// assertion helpers shared by the rtl
// each macro expands to a concurrent assertion in simulation and to nothing
// in synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define SALC_ASSERT_IMP(label, clk_s, rstn_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication
`define SALC_ASSERT_NXT(label, clk_s, rstn_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define SALC_ASSERT_IMP(label, clk_s, rstn_s, ante, cons)
`define SALC_ASSERT_NXT(label, clk_s, rstn_s, ante, cons)

`endif

`endif

// ===== rtl/core/salc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// salc_pkg
// Shared widths and constants of the set-associative LRU cache model.
// ----------------------------------------------------------------------------
package salc_pkg;

    localparam int ADDR_W = 32;
    localparam int MISS_W = 32;

    // cache geometry, both powers of two
    localparam int LINE_SIZE = 64;
    localparam int SET_COUNT = 32;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [MISS_W-1:0] miss_t;

    localparam miss_t MISS_MAX = '1;

endpackage
`default_nettype wire

// ===== rtl/core/set_assoc_lru_cache_model.sv =====
`timescale 1ns / 1ps
`default_nettype none
// path: each address passes the lookup register, then the result register
// throughput: one address per cycle while out_ready does not stall the
// result register, set by the single write port of the tag/age memories
// with a one-row bypass between back-to-back accesses
// reset: asynchronous, clears every valid bit, the miss counter and the
// pipeline at once; no clearing pass, the block is ready right after reset
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_model
// Set-associative cache directory with true LRU replacement. Each address
// is looked up, the set's ranks and tags are updated, and hit, eviction and
// the saturating miss count are returned.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module set_assoc_lru_cache_model #(
    parameter int WAY_COUNT  = 4,
    parameter int ADDR_BITS  = 32
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output      logic                  in_ready,
    input  wire salc_pkg::addr_t       address,
    output      logic                  out_valid,
    input  wire logic                  out_ready,
    output      logic                  hit,
    output      logic                  evicted,
    output      salc_pkg::miss_t       miss_total
);

    localparam int OFFSET_BITS  = $clog2(salc_pkg::LINE_SIZE);
    localparam int SET_BITS     = $clog2(salc_pkg::SET_COUNT);
    localparam int SET_IDX_BITS = (salc_pkg::SET_COUNT > 1) ? SET_BITS : 1;
    localparam int WAY_IDX_BITS = (WAY_COUNT > 1) ? $clog2(WAY_COUNT) : 1;
    localparam int AGE_BITS     = WAY_IDX_BITS;
    localparam int LINE_W       = salc_pkg::ADDR_W - OFFSET_BITS;
    localparam int TAG_BITS     = LINE_W - SET_BITS;

    localparam salc_pkg::addr_t ADDR_MASK = (ADDR_BITS >= salc_pkg::ADDR_W) ?
        '1 : salc_pkg::addr_t'((64'd1 << ADDR_BITS) - 64'd1);
    localparam logic [LINE_W-1:0] SET_MASK = LINE_W'(salc_pkg::SET_COUNT - 1);

    typedef logic [TAG_BITS-1:0]                     tag_t;
    typedef logic [AGE_BITS-1:0]                     age_t;
    typedef logic [SET_IDX_BITS-1:0]                 set_idx_t;
    typedef logic [WAY_IDX_BITS-1:0]                 way_idx_t;
    typedef logic [WAY_COUNT-1:0][TAG_BITS-1:0]      tag_row_t;
    typedef logic [WAY_COUNT-1:0][AGE_BITS-1:0]      age_row_t;

    // input decode
    salc_pkg::addr_t    in_addr_m;
    logic [LINE_W-1:0]  in_line;
    set_idx_t           in_set;
    tag_t               in_tag;

    // memories and bypass
    tag_row_t           tag_mem [salc_pkg::SET_COUNT];
    age_row_t           age_mem [salc_pkg::SET_COUNT];
    tag_row_t           tag_rd_reg;
    age_row_t           age_rd_reg;
    logic               fwd_reg;
    tag_row_t           fwd_tags_reg;
    age_row_t           fwd_ages_reg;

    logic [salc_pkg::SET_COUNT-1:0][WAY_COUNT-1:0] valid_reg;

    // lookup stage
    logic               s1_valid_reg;
    set_idx_t           s1_set_reg;
    tag_t               s1_tag_reg;
    logic               s1_go;
    logic               in_fire;

    tag_row_t           cur_tags;
    age_row_t           cur_ages;
    logic [WAY_COUNT-1:0] cur_valid;
    logic [WAY_COUNT-1:0] hit_vec;
    logic               s1_hit;
    logic               s1_evict;
    logic               hit_found;
    logic               free_found;
    way_idx_t           hit_way;
    way_idx_t           free_way;
    way_idx_t           victim;
    way_idx_t           slot;
    age_t               limit_age;
    tag_row_t           new_tags;
    age_row_t           new_ages;

    salc_pkg::miss_t    miss_reg;
    salc_pkg::miss_t    miss_next;

    // result register
    logic               out_valid_reg;
    logic               hit_reg;
    logic               evicted_reg;
    salc_pkg::miss_t    miss_total_reg;

    assign in_addr_m = address & ADDR_MASK;
    assign in_line   = LINE_W'(in_addr_m >> OFFSET_BITS);
    assign in_set    = SET_IDX_BITS'(in_line & SET_MASK);
    assign in_tag    = TAG_BITS'(in_line >> SET_BITS);

    assign s1_go    = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_go;
    assign in_fire  = in_valid && in_ready;

    always_ff @(posedge clk)
    begin
        if (s1_go)
        begin
            tag_mem[s1_set_reg] <= new_tags;
            age_mem[s1_set_reg] <= new_ages;
        end
        if (in_fire)
        begin
            tag_rd_reg <= tag_mem[in_set];
            age_rd_reg <= age_mem[in_set];
        end
    end

    // row written in the same cycle as the read of the same set
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            fwd_tags_reg <= new_tags;
            fwd_ages_reg <= new_ages;
            s1_set_reg   <= in_set;
            s1_tag_reg   <= in_tag;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg      <= 1'b0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                fwd_reg      <= s1_go && (in_set == s1_set_reg);
                s1_valid_reg <= 1'b1;
            end
            else if (s1_go)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    assign cur_tags  = fwd_reg ? fwd_tags_reg : tag_rd_reg;
    assign cur_ages  = fwd_reg ? fwd_ages_reg : age_rd_reg;
    assign cur_valid = valid_reg[s1_set_reg];

    always_comb
    begin
        hit_vec    = '0;
        hit_found  = 1'b0;
        free_found = 1'b0;
        hit_way    = '0;
        free_way   = '0;
        victim     = '0;
        for (int w = 0; w < WAY_COUNT; w++)
        begin
            hit_vec[w] = cur_valid[w] && (cur_tags[w] == s1_tag_reg);
        end
        for (int w = 0; w < WAY_COUNT; w++)
        begin
            if (hit_vec[w] && !hit_found)
            begin
                hit_way   = WAY_IDX_BITS'(w);
                hit_found = 1'b1;
            end
            if (!cur_valid[w] && !free_found)
            begin
                free_way   = WAY_IDX_BITS'(w);
                free_found = 1'b1;
            end
        end
        // oldest rank, lower way on a tie
        for (int w = 1; w < WAY_COUNT; w++)
        begin
            if (cur_ages[w] > cur_ages[victim])
            begin
                victim = WAY_IDX_BITS'(w);
            end
        end
        s1_hit    = hit_found;
        s1_evict  = !hit_found && !free_found;
        slot      = hit_found ? hit_way : (free_found ? free_way : victim);
        limit_age = cur_ages[hit_way];
        for (int w = 0; w < WAY_COUNT; w++)
        begin
            new_tags[w] = cur_tags[w];
            new_ages[w] = cur_ages[w];
            if (WAY_IDX_BITS'(w) == slot)
            begin
                new_ages[w] = '0;
                if (!hit_found)
                begin
                    new_tags[w] = s1_tag_reg;
                end
            end
            else if (cur_valid[w] && (!hit_found || (cur_ages[w] < limit_age)))
            begin
                new_ages[w] = cur_ages[w] + AGE_BITS'(1);
            end
        end
        miss_next = miss_reg;
        if (!hit_found && (miss_reg != salc_pkg::MISS_MAX))
        begin
            miss_next = miss_reg + salc_pkg::MISS_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            miss_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_go)
            begin
                valid_reg[s1_set_reg][slot] <= 1'b1;
                miss_reg      <= miss_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go)
        begin
            hit_reg        <= s1_hit;
            evicted_reg    <= s1_evict;
            miss_total_reg <= miss_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign hit        = hit_reg;
    assign evicted    = evicted_reg;
    assign miss_total = miss_total_reg;

    `SALC_ASSERT_IMP(a_evict_not_hit, clk, rst_n, out_valid_reg, !(hit_reg && evicted_reg))
    `SALC_ASSERT_IMP(a_evict_full_set, clk, rst_n, s1_go && s1_evict, &cur_valid)
    `SALC_ASSERT_IMP(a_single_match, clk, rst_n, s1_valid_reg, $onehot0(hit_vec))
    `SALC_ASSERT_NXT(a_hit_keeps_count, clk, rst_n, s1_go && s1_hit, miss_reg == $past(miss_reg))

endmodule
`default_nettype wire

// ===== verif/set_assoc_lru_cache_model_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_model_test
// Self-checking bench for the 4-way LRU cache directory. Addresses are driven
// over a valid/ready channel. A scoreboard keeps its own copy of the sets and
// the miss counter and predicts hit, eviction and miss count for every
// address. Each result transfer is compared in order. The run starts with
// directed accesses and then sends random ones under varied handshake
// pressure.
// ----------------------------------------------------------------------------

typedef struct packed
{
    logic            hit;
    logic            evicted;
    salc_pkg::miss_t miss_total;
} cache_lookup_t;

class cache_scoreboard;

    localparam int SETS        = salc_pkg::SET_COUNT;
    localparam int WAYS        = 4;
    localparam int OFFSET_BITS = $clog2(salc_pkg::LINE_SIZE);
    localparam int SET_BITS    = $clog2(salc_pkg::SET_COUNT);
    localparam int TAG_BITS    = salc_pkg::ADDR_W - OFFSET_BITS - SET_BITS;

    bit                  way_used [SETS*WAYS];
    logic [TAG_BITS-1:0] way_tag  [SETS*WAYS];
    logic [1:0]          way_rank [SETS*WAYS];
    salc_pkg::miss_t     misses;
    cache_lookup_t       expected_lookups[$];
    int                  failures;

    function new();
        for (int i = 0; i < SETS*WAYS; i++)
        begin
            way_used[i] = 1'b0;
            way_tag[i]  = '0;
            way_rank[i] = '0;
        end
        misses   = '0;
        failures = 0;
    endfunction

    function void note_access(salc_pkg::addr_t addr);
        int                  base;
        int                  slot;
        logic [TAG_BITS-1:0] tag;
        logic [1:0]          limit;
        cache_lookup_t       res;
        base = int'(addr[OFFSET_BITS +: SET_BITS]) * WAYS;
        tag  = addr[OFFSET_BITS+SET_BITS +: TAG_BITS];
        slot = -1;
        res  = '0;
        for (int w = 0; w < WAYS; w++)
            if (slot < 0 && way_used[base+w] && way_tag[base+w] == tag)
                slot = w;
        if (slot >= 0)
        begin
            res.hit = 1'b1;
            limit   = way_rank[base+slot];
            for (int w = 0; w < WAYS; w++)
                if (w != slot && way_used[base+w] && way_rank[base+w] < limit)
                    way_rank[base+w] = way_rank[base+w] + 2'd1;
        end
        else
        begin
            if (misses != salc_pkg::MISS_MAX)
                misses = misses + 1'b1;
            for (int w = 0; w < WAYS; w++)
                if (slot < 0 && !way_used[base+w])
                    slot = w;
            // full set: the oldest way goes
            if (slot < 0)
            begin
                slot = 0;
                for (int w = 1; w < WAYS; w++)
                    if (way_rank[base+w] > way_rank[base+slot])
                        slot = w;
                res.evicted = 1'b1;
            end
            way_used[base+slot] = 1'b0;
            way_tag[base+slot]  = tag;
            for (int w = 0; w < WAYS; w++)
                if (w != slot && way_used[base+w])
                    way_rank[base+w] = way_rank[base+w] + 2'd1;
            way_used[base+slot] = 1'b1;
        end
        way_rank[base+slot] = '0;
        res.miss_total = misses;
        expected_lookups.push_back(res);
    endfunction

    function void check_result(logic hit, logic evicted, salc_pkg::miss_t miss_total);
        cache_lookup_t want;
        if (expected_lookups.size() == 0)
        begin
            $error("result transfer with no access outstanding");
            failures++;
            return;
        end
        want = expected_lookups.pop_front();
        if (hit !== want.hit)
        begin
            $error("hit: expected %0d, got %0d", want.hit, hit);
            failures++;
        end
        if (evicted !== want.evicted)
        begin
            $error("evicted: expected %0d, got %0d", want.evicted, evicted);
            failures++;
        end
        if (miss_total !== want.miss_total)
        begin
            $error("miss_total: expected %0d, got %0d", want.miss_total, miss_total);
            failures++;
        end
    endfunction

    function int pending();
        return expected_lookups.size();
    endfunction

endclass

module set_assoc_lru_cache_model_test;

    logic            clk;
    logic            rst_n;
    logic            in_valid;
    logic            in_ready;
    salc_pkg::addr_t address;
    logic            out_valid;
    logic            out_ready;
    logic            hit;
    logic            evicted;
    salc_pkg::miss_t miss_total;

    int          sender_idle_pct;
    int          receiver_stall_pct;
    int          hold_cycles;
    logic [20:0] tag_salt;

    cache_scoreboard board;

    set_assoc_lru_cache_model i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .address    (address),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .hit        (hit),
        .evicted    (evicted),
        .miss_total (miss_total)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("set_assoc_lru_cache_model_test failed");
        $finish;
    end

    // receiver side, with an optional long hold-off
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                out_ready <= 1'b0;
                hold_cycles--;
            end
            else
                out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_result(hit, evicted, miss_total);
    end

    task automatic send_access(salc_pkg::addr_t addr);
        @(negedge clk);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        address  <= addr;
        do
            @(posedge clk);
        while (!in_ready);
        board.note_access(addr);
    endtask

    task automatic wait_for_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    // mostly a few tags per hot set so that hits and evictions are frequent
    function automatic salc_pkg::addr_t make_address();
        logic [20:0] tag;
        logic [4:0]  set_idx;
        if ($urandom_range(0, 99) < 30)
            return $urandom;
        case ($urandom_range(0, 3))
            0:       set_idx = '0;
            1:       set_idx = '1;
            2:       set_idx = 5'd5;
            default: set_idx = 5'($urandom_range(0, 31));
        endcase
        tag = tag_salt ^ 21'($urandom_range(0, 5));
        return {tag, set_idx, 6'($urandom)};
    endfunction

    initial
    begin
        salc_pkg::addr_t directed [21] = '{
            32'h0000_0000, 32'h0000_003F, 32'hFFFF_FFFF, 32'hFFFF_FFC0,
            32'h0000_0800, 32'h0000_1000, 32'h0000_1800, 32'h0000_0010,
            32'h0000_2000, 32'h0000_0800, 32'h0000_1820, 32'h0000_2000,
            32'h0000_1000, 32'hFFFF_F7C0, 32'hFFFF_EFC0, 32'hFFFF_E7C0,
            32'h0000_07C0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
            32'hFFFF_F7FF
        };
        board              = new();
        rst_n              = 1'b0;
        in_valid           = 1'b0;
        address            = '0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        hold_cycles        = 0;
        tag_salt           = 21'($urandom);
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed[i])
            send_access(directed[i]);
        wait_for_results();

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                end
                1:
                begin
                    sender_idle_pct    = 68;
                    receiver_stall_pct = 0;
                end
                2:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 68;
                end
                default:
                begin
                    sender_idle_pct    = 20;
                    receiver_stall_pct = 20;
                end
            endcase
            for (int n = 0; n < 210; n++)
            begin
                if (phase == 0 && n == 40)
                    hold_cycles = 60;
                send_access(make_address());
            end
            wait_for_results();
        end

        repeat (4) @(posedge clk);
        if (board.pending() != 0)
        begin
            $error("%0d results never arrived", board.pending());
            board.failures++;
        end
        if (board.failures == 0)
            $display("set_assoc_lru_cache_model_test passed");
        else
            $display("set_assoc_lru_cache_model_test failed");
        $finish;
    end

endmodule
